### hw/rtl/jeop_pkg.sv
// Shared constants, parser phase codes and helper functions for the EXIF orientation parser.
package jeop_pkg;

  typedef logic [3:0] phase_t;
  typedef logic [1:0] status_t;

  localparam phase_t PH_SOI0   = 4'd0;
  localparam phase_t PH_SOI1   = 4'd1;
  localparam phase_t PH_MK0    = 4'd2;
  localparam phase_t PH_MK1    = 4'd3;
  localparam phase_t PH_LENH   = 4'd4;
  localparam phase_t PH_LENL   = 4'd5;
  localparam phase_t PH_LENH_A = 4'd6;
  localparam phase_t PH_LENL_A = 4'd7;
  localparam phase_t PH_SKIP   = 4'd8;
  localparam phase_t PH_HDR    = 4'd9;
  localparam phase_t PH_SEEK   = 4'd10;
  localparam phase_t PH_COUNT  = 4'd11;
  localparam phase_t PH_ENTRY  = 4'd12;
  localparam phase_t PH_DONE   = 4'd13;

  localparam status_t ST_FOUND    = 2'd0;
  localparam status_t ST_NOT_JPEG = 2'd1;
  localparam status_t ST_NO_TAG   = 2'd2;
  localparam status_t ST_BAD_TIFF = 2'd3;

  localparam logic [7:0]  MK_PREFIX   = 8'hFF;
  localparam logic [7:0]  MK_SOI      = 8'hD8;
  localparam logic [7:0]  MK_EOI      = 8'hD9;
  localparam logic [7:0]  MK_SOS      = 8'hDA;
  localparam logic [7:0]  MK_APP1     = 8'hE1;
  localparam logic [7:0]  BYTE_ORDER_II = 8'h49;
  localparam logic [15:0] TAG_ORIENT  = 16'h0112;
  localparam logic [15:0] TIFF_MAGIC  = 16'd42;
  localparam logic [15:0] EXIF_MIN_LEN = 16'd16;
  localparam logic [15:0] DEFAULT_ORIENT = 16'd1;
  localparam logic [3:0]  ENTRY_LAST_IDX = 4'd11;

  // "Exif\0\0"
  function automatic logic [7:0] exif_sig(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'h45;
      3'd1:    val = 8'h78;
      3'd2:    val = 8'h69;
      3'd3:    val = 8'h66;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  // leave the segment when its payload is used up, else skip the rest
  function automatic phase_t leave_phase(input logic [15:0] pos, input logic [15:0] len);
    return (pos >= len) ? PH_MK0 : PH_SKIP;
  endfunction

endpackage

### hw/rtl/jpeg_exif_orientation_parser.sv
// JPEG marker walker and EXIF IFD0 scanner that reports the orientation tag once per file.
// A result word is registered in the result register behind out_valid, or in the skid word.
// One byte per cycle when in_stall is low; a byte only updates counters and small registers.
// A two-entry buffer (result register plus skid) keeps input going under out_stall until full.
// Reset (rst, synchronous, active high) returns the parser to wait for the first SOI byte
// and empties the output buffer; an accepted byte with last_byte set also rearms the parser.
module jpeg_exif_orientation_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] orientation,
  output logic [1:0]  status
);

  jeop_pkg::phase_t phase, phase_next;
  logic [15:0] segment_length, segment_length_next;
  logic [15:0] segment_position, segment_position_next;
  logic        little_endian, little_endian_next;
  logic [31:0] directory_offset, directory_offset_next;
  logic [15:0] entries_left, entries_left_next;
  logic [3:0]  entry_byte_index, entry_byte_index_next;
  logic [15:0] gathered_word, gathered_word_next;
  logic        tag_matches, tag_matches_next;

  logic        skid_valid;
  logic [15:0] skid_orientation;
  logic [1:0]  skid_status;

  logic        accept;
  logic        have;
  jeop_pkg::status_t res_status;
  logic [15:0] res_orient;
  logic [15:0] joined;
  logic [15:0] pos_inc;
  logic [15:0] len_word;
  logic [15:0] entries_dec;
  logic [31:0] off_new;
  logic        res_word;

  assign accept   = in_valid && !in_stall;
  assign in_stall = skid_valid;
  assign joined   = little_endian ? {data_byte, gathered_word[7:0]}
                                  : {gathered_word[7:0], data_byte};
  assign pos_inc  = segment_position + 16'd1;
  assign len_word = segment_length | {8'h00, data_byte};
  assign entries_dec = entries_left - 16'd1;

  always_comb begin
    phase_next            = phase;
    segment_length_next   = segment_length;
    segment_position_next = segment_position;
    little_endian_next    = little_endian;
    directory_offset_next = directory_offset;
    entries_left_next     = entries_left;
    entry_byte_index_next = entry_byte_index;
    gathered_word_next    = gathered_word;
    tag_matches_next      = tag_matches;
    have                  = 1'b0;
    res_status            = jeop_pkg::ST_NO_TAG;
    res_orient            = jeop_pkg::DEFAULT_ORIENT;
    off_new               = directory_offset;

    case (phase)
      jeop_pkg::PH_SOI0: begin
        if (data_byte != jeop_pkg::MK_PREFIX) begin
          have = 1'b1;
          res_status = jeop_pkg::ST_NOT_JPEG;
        end else begin
          phase_next = jeop_pkg::PH_SOI1;
        end
      end
      jeop_pkg::PH_SOI1: begin
        if (data_byte != jeop_pkg::MK_SOI) begin
          have = 1'b1;
          res_status = jeop_pkg::ST_NOT_JPEG;
        end else begin
          phase_next = jeop_pkg::PH_MK0;
        end
      end
      jeop_pkg::PH_MK0: begin
        if (data_byte != jeop_pkg::MK_PREFIX) have = 1'b1;
        else phase_next = jeop_pkg::PH_MK1;
      end
      jeop_pkg::PH_MK1: begin
        if (data_byte == jeop_pkg::MK_EOI || data_byte == jeop_pkg::MK_SOS) have = 1'b1;
        else if (data_byte == jeop_pkg::MK_APP1) phase_next = jeop_pkg::PH_LENH_A;
        else phase_next = jeop_pkg::PH_LENH;
      end
      jeop_pkg::PH_LENH, jeop_pkg::PH_LENH_A: begin
        segment_length_next = {data_byte, 8'h00};
        phase_next = phase + 4'd1;
      end
      jeop_pkg::PH_LENL, jeop_pkg::PH_LENL_A: begin
        if (len_word < 16'd2) begin
          have = 1'b1;
        end else begin
          segment_length_next   = len_word - 16'd2;
          segment_position_next = 16'd0;
          if (phase == jeop_pkg::PH_LENL_A && segment_length_next >= jeop_pkg::EXIF_MIN_LEN)
            phase_next = jeop_pkg::PH_HDR;
          else
            phase_next = jeop_pkg::leave_phase(16'd0, segment_length_next);
        end
      end
      jeop_pkg::PH_SKIP: begin
        segment_position_next = pos_inc;
        phase_next = jeop_pkg::leave_phase(pos_inc, segment_length);
      end
      jeop_pkg::PH_HDR: begin
        segment_position_next = pos_inc;
        if (segment_position < 16'd6) begin
          if (data_byte != jeop_pkg::exif_sig(segment_position[2:0]))
            phase_next = jeop_pkg::leave_phase(pos_inc, segment_length);
        end else begin
          case (segment_position)
            16'd6: little_endian_next = (data_byte == jeop_pkg::BYTE_ORDER_II);
            16'd7: if (data_byte != jeop_pkg::BYTE_ORDER_II) little_endian_next = 1'b0;
            16'd8: gathered_word_next = {8'h00, data_byte};
            16'd9: begin
              if (joined != jeop_pkg::TIFF_MAGIC) begin
                have = 1'b1;
                res_status = jeop_pkg::ST_BAD_TIFF;
              end
            end
            16'd10: directory_offset_next = {24'h0, data_byte};
            default: begin
              if (!little_endian) off_new = {directory_offset[23:0], data_byte};
              else if (segment_position == 16'd11)
                off_new = directory_offset | {16'h0, data_byte, 8'h00};
              else if (segment_position == 16'd12)
                off_new = directory_offset | {8'h00, data_byte, 16'h0};
              else
                off_new = directory_offset | {data_byte, 24'h0};
              directory_offset_next = off_new;
              if (segment_position == 16'd13) begin
                if (off_new < 32'd8 ||
                    ({1'b0, off_new} + 33'd8) > {17'h0, segment_length}) begin
                  have = 1'b1;
                  res_status = jeop_pkg::ST_BAD_TIFF;
                end else if (off_new == 32'd8) begin
                  phase_next = jeop_pkg::PH_COUNT;
                  entry_byte_index_next = 4'd0;
                end else begin
                  phase_next = jeop_pkg::PH_SEEK;
                end
              end
            end
          endcase
        end
      end
      jeop_pkg::PH_SEEK: begin
        segment_position_next = pos_inc;
        if ({17'h0, pos_inc} >= ({1'b0, directory_offset} + 33'd6)) begin
          phase_next = jeop_pkg::PH_COUNT;
          entry_byte_index_next = 4'd0;
        end
      end
      jeop_pkg::PH_COUNT: begin
        segment_position_next = pos_inc;
        if (entry_byte_index == 4'd0) begin
          gathered_word_next    = {8'h00, data_byte};
          entry_byte_index_next = 4'd1;
        end else begin
          entries_left_next = joined;
          if (joined == 16'd0 || ({1'b0, pos_inc} + 17'd12) > {1'b0, segment_length}) begin
            phase_next = jeop_pkg::leave_phase(pos_inc, segment_length);
          end else begin
            phase_next = jeop_pkg::PH_ENTRY;
            entry_byte_index_next = 4'd0;
            tag_matches_next = 1'b0;
          end
        end
      end
      jeop_pkg::PH_ENTRY: begin
        if (entry_byte_index == 4'd9 && tag_matches) begin
          have = 1'b1;
          res_status = jeop_pkg::ST_FOUND;
          res_orient = joined;
        end else begin
          if (entry_byte_index inside {4'd0, 4'd8}) gathered_word_next = {8'h00, data_byte};
          else if (entry_byte_index == 4'd1) tag_matches_next = (joined == jeop_pkg::TAG_ORIENT);
          segment_position_next = pos_inc;
          if (entry_byte_index >= jeop_pkg::ENTRY_LAST_IDX) begin
            entries_left_next = entries_dec;
            if (entries_dec == 16'd0 ||
                ({1'b0, pos_inc} + 17'd12) > {1'b0, segment_length}) begin
              phase_next = jeop_pkg::leave_phase(pos_inc, segment_length);
            end else begin
              entry_byte_index_next = 4'd0;
              tag_matches_next = 1'b0;
            end
          end else begin
            entry_byte_index_next = entry_byte_index + 4'd1;
          end
        end
      end
      default: ;
    endcase

    // end of file without an answer
    if (!have && last_byte && phase != jeop_pkg::PH_DONE) begin
      have = 1'b1;
      res_status = (phase_next == jeop_pkg::PH_SOI0 || phase_next == jeop_pkg::PH_SOI1)
                   ? jeop_pkg::ST_NOT_JPEG : jeop_pkg::ST_NO_TAG;
    end
    if (have) begin
      phase_next = jeop_pkg::PH_DONE;
      if (res_status != jeop_pkg::ST_FOUND) res_orient = jeop_pkg::DEFAULT_ORIENT;
    end
    if (last_byte) begin
      phase_next            = jeop_pkg::PH_SOI0;
      segment_length_next   = 16'd0;
      segment_position_next = 16'd0;
      little_endian_next    = 1'b0;
      directory_offset_next = 32'd0;
      entries_left_next     = 16'd0;
      entry_byte_index_next = 4'd0;
      gathered_word_next    = 16'd0;
      tag_matches_next      = 1'b0;
    end
  end

  assign res_word = accept && have;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= jeop_pkg::PH_SOI0;
      segment_length   <= 16'd0;
      segment_position <= 16'd0;
      little_endian    <= 1'b0;
      directory_offset <= 32'd0;
      entries_left     <= 16'd0;
      entry_byte_index <= 4'd0;
      gathered_word    <= 16'd0;
      tag_matches      <= 1'b0;
    end else if (accept) begin
      phase            <= phase_next;
      segment_length   <= segment_length_next;
      segment_position <= segment_position_next;
      little_endian    <= little_endian_next;
      directory_offset <= directory_offset_next;
      entries_left     <= entries_left_next;
      entry_byte_index <= entry_byte_index_next;
      gathered_word    <= gathered_word_next;
      tag_matches      <= tag_matches_next;
    end
  end

  // result register with skid word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= res_word;
      end else begin
        out_valid  <= res_word;
      end
    end else if (res_word) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        orientation <= skid_orientation;
        status      <= skid_status;
        if (res_word) begin
          skid_orientation <= res_orient;
          skid_status      <= res_status;
        end
      end else if (res_word) begin
        orientation <= res_orient;
        status      <= res_status;
      end
    end else if (res_word) begin
      skid_orientation <= res_orient;
      skid_status      <= res_status;
    end
  end

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid) else $error("skid word held with empty result register");

  a_last_rearms: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> phase == jeop_pkg::PH_SOI0)
    else $error("parser did not rearm after last byte");

  a_last_answers: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte && phase != jeop_pkg::PH_DONE |=> out_valid)
    else $error("file ended without a result word");

  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    accept && phase == jeop_pkg::PH_DONE |-> !have)
    else $error("second result word for one file");

  a_entry_index: assert property (@(posedge clk) disable iff (rst)
    entry_byte_index <= jeop_pkg::ENTRY_LAST_IDX)
    else $error("entry byte index out of range");
`endif

endmodule
